[hw/rtl/hbd_pkg.sv]
// Shared types, constants and the coefficient table of the half-band decimator.
// Depends on nothing; every module of the block imports it.
package hbd_pkg;

    localparam int DATA_W        = 16;
    localparam int COEF_W        = 16;
    localparam int PROD_W        = DATA_W + COEF_W;
    localparam int ACC_W         = 40;
    localparam int FRAC_W        = 15;
    localparam int RND_W         = ACC_W - FRAC_W;
    localparam int TAP_COUNT_DEF = 91;
    localparam int ROM_TAPS      = 91;
    localparam int ROM_HALF      = 46;
    localparam int HALF_W        = 6;
    localparam int K_W           = 8;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0] coef_t;

    // Unique half of the symmetric lowpass taps, Q1.15
    localparam coef_t TAP_HALF [ROM_HALF] = '{
        16'sd24,    -16'sd23,   -16'sd41,   16'sd16,    16'sd58,
        16'sd0,     -16'sd73,   -16'sd25,   16'sd81,    16'sd59,
        -16'sd78,   -16'sd98,   16'sd60,    16'sd139,   -16'sd25,
        -16'sd173,  -16'sd30,   16'sd195,   16'sd101,   -16'sd195,
        -16'sd185,  16'sd166,   16'sd273,   -16'sd103,  -16'sd355,
        16'sd0,     16'sd417,   16'sd142,   -16'sd444,  -16'sd319,
        16'sd419,   16'sd524,   -16'sd323,  -16'sd746,  16'sd136,
        16'sd972,   16'sd171,   -16'sd1186, -16'sd654,  16'sd1372,
        16'sd1450,  -16'sd1516, -16'sd3079, 16'sd1607,  16'sd10297,
        16'sd14749
    };

    // Commands from the controller to the datapath
    typedef struct packed {
        logic write;     // store the accepted sample
        logic start;     // set up a new sum of products
        logic issue;     // read one tap pair and advance
        logic out_load;  // round, saturate and present the result
    } hbd_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last_step;  // the pair being issued is the final one
        logic pipe_busy;  // products still on their way to the accumulator
        logic out_free;   // the output register can take a result
    } hbd_sts_t;

    // Tap k of the lowpass; taps past the table are zero
    function automatic coef_t coef_at(input logic [K_W-1:0] k);
        logic [K_W-1:0] j;
        j = (k < K_W'(ROM_HALF)) ? k : (K_W'(ROM_TAPS - 1) - k);
        if (k >= K_W'(ROM_TAPS))
        begin
            return '0;
        end
        return TAP_HALF[j[HALF_W-1:0]];
    endfunction

endpackage

[hw/rtl/hbd_ctrl.sv]
// Controller of the half-band decimator: intake, decimation phase and MAC sequencing.
// Depends on hbd_pkg for the command and status structs.
module hbd_ctrl
    import hbd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  hbd_sts_t sts,
    output hbd_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ISSUE = 3'b010,
        S_DRAIN = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;
    logic   accept;

    // Take samples only while no sum is in progress
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // Decode commands
    always_comb
    begin
        cmd.write    = accept;
        cmd.start    = accept && !phase_reg;
        cmd.issue    = (state_reg == S_ISSUE);
        cmd.out_load = (state_reg == S_DRAIN) && !sts.pipe_busy && sts.out_free;
    end

    // Toggle the phase on every transaction; even transactions emit
    assign phase_next = accept ? !phase_reg : phase_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                    state_next = S_ISSUE;
            end
            S_ISSUE:
            begin
                if (sts.last_step)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (cmd.out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

[hw/rtl/hbd_datapath.sv]
// Datapath of the half-band decimator: circular delay-line memory, tap-pair
// multipliers, accumulator and the rounding and saturating output register.
// Depends on hbd_pkg for widths, the coefficient table and the control structs.
module hbd_datapath
    import hbd_pkg::*;
#(
    parameter int TAP_COUNT = TAP_COUNT_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  hbd_cmd_t cmd,
    output hbd_sts_t sts,
    input  sample_t  in_sample,
    input  logic     out_ready,
    output logic     out_valid,
    output sample_t  out_sample,
    output logic     saturated
);

    localparam int ADDR_W = $clog2(TAP_COUNT);
    localparam int STEPS  = (TAP_COUNT + 1) / 2;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TAP_COUNT - 1);
    localparam logic [ADDR_W-1:0] LAST_STEP = ADDR_W'(STEPS - 1);
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_W - 1));
    localparam logic signed [RND_W-1:0] SAT_MAX = RND_W'(32767);
    localparam logic signed [RND_W-1:0] SAT_MIN = -RND_W'(32768);

    // Delay line memory with one valid bit per entry
    sample_t              mem [TAP_COUNT];
    logic [TAP_COUNT-1:0] vld_reg;

    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] addr_a_reg, addr_a_next;
    logic [ADDR_W-1:0] addr_b_reg, addr_b_next;
    logic [ADDR_W-1:0] ka_reg;
    logic [ADDR_W-1:0] kb;

    sample_t xa_reg, xb_reg;
    logic    va_reg, vb_reg;
    coef_t   ca_reg, cb_reg;
    logic    skip_b_reg;
    logic    rd_v_reg;
    sample_t xa_eff, xb_eff;

    logic signed [PROD_W-1:0] pa_reg, pb_reg;
    logic                     mul_v_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    logic signed [ACC_W-1:0] biased;
    logic signed [RND_W-1:0] rnd;
    sample_t                 res_sample;
    logic                    res_sat;

    logic    out_valid_reg;
    sample_t out_sample_reg;
    logic    saturated_reg;

    assign kb = LAST_ADDR - ka_reg;

    // Pointer arithmetic with wrap at the delay-line length
    assign wr_ptr_next = (wr_ptr_reg == LAST_ADDR) ? '0 : wr_ptr_reg + 1'b1;

    always_comb
    begin
        addr_a_next = addr_a_reg;
        addr_b_next = addr_b_reg;
        if (cmd.start)
        begin
            addr_a_next = wr_ptr_reg;
            addr_b_next = wr_ptr_next;
        end
        else if (cmd.issue)
        begin
            addr_a_next = (addr_a_reg == '0) ? LAST_ADDR : addr_a_reg - 1'b1;
            addr_b_next = (addr_b_reg == LAST_ADDR) ? '0 : addr_b_reg + 1'b1;
        end
    end

    // Write the new sample, read one tap pair
    always_ff @(posedge clk)
    begin
        if (cmd.write)
            mem[wr_ptr_reg] <= in_sample;
        if (cmd.issue)
        begin
            xa_reg     <= mem[addr_a_reg];
            xb_reg     <= mem[addr_b_reg];
            ca_reg     <= coef_at(K_W'(ka_reg));
            cb_reg     <= coef_at(K_W'(kb));
            skip_b_reg <= (ka_reg == kb);
        end
    end

    // Control state: pointers, valid bits, pipeline flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            wr_ptr_reg <= '0;
            addr_a_reg <= '0;
            addr_b_reg <= '0;
            ka_reg     <= '0;
            va_reg     <= 1'b0;
            vb_reg     <= 1'b0;
            rd_v_reg   <= 1'b0;
            mul_v_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.write)
            begin
                vld_reg[wr_ptr_reg] <= 1'b1;
                wr_ptr_reg          <= wr_ptr_next;
            end
            addr_a_reg <= addr_a_next;
            addr_b_reg <= addr_b_next;
            if (cmd.start)
                ka_reg <= '0;
            else if (cmd.issue)
                ka_reg <= ka_reg + 1'b1;
            if (cmd.issue)
            begin
                va_reg <= vld_reg[addr_a_reg];
                vb_reg <= vld_reg[addr_b_reg];
            end
            rd_v_reg  <= cmd.issue;
            mul_v_reg <= rd_v_reg;
        end
    end

    // Entries never written read as zero; the center tap counts once
    assign xa_eff = va_reg ? xa_reg : '0;
    assign xb_eff = (vb_reg && !skip_b_reg) ? xb_reg : '0;

    // Multiply, then accumulate
    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
        begin
            pa_reg <= xa_eff * ca_reg;
            pb_reg <= xb_eff * cb_reg;
        end
        if (cmd.start)
            acc_reg <= '0;
        else if (mul_v_reg)
            acc_reg <= acc_reg + ACC_W'(pa_reg) + ACC_W'(pb_reg);
    end

    // Round half up, then clip to 16 bits
    always_comb
    begin
        biased     = acc_reg + ROUND_HALF;
        rnd        = RND_W'(biased >>> FRAC_W);
        res_sat    = 1'b0;
        res_sample = DATA_W'(rnd);
        if (rnd > SAT_MAX)
        begin
            res_sample = DATA_W'(SAT_MAX);
            res_sat    = 1'b1;
        end
        else if (rnd < SAT_MIN)
        begin
            res_sample = DATA_W'(SAT_MIN);
            res_sat    = 1'b1;
        end
    end

    // Output register: hold until the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_sample_reg <= res_sample;
            saturated_reg  <= res_sat;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;
    assign saturated  = saturated_reg;

    always_comb
    begin
        sts.last_step = (ka_reg == LAST_STEP);
        sts.pipe_busy = rd_v_reg || mul_v_reg;
        sts.out_free  = !out_valid_reg || out_ready;
    end

endmodule

[hw/rtl/halfband_fir_decimator_top.sv]
// Half-band lowpass FIR decimator by two.
// Input: s_axis stream of signed 16-bit samples; output: m_axis stream of
// filtered samples, one for every second input transaction, starting with
// the first after reset.
// Each sample goes into a circular delay line of TAP_COUNT entries. An input
// that does not produce a result is written there, and intake stays open. An
// input that does starts a sum of products over (TAP_COUNT+1)/2 tap pairs,
// one pair per cycle through two 16x16 multipliers, then drains the multiply
// and accumulate stages; s_axis_tready is low after the transaction until the
// result is loaded into the output register.
// The result waits in an output register; while the receiver stalls, the
// next odd input is still taken, and the following sum finishes but is held
// until the output register is free.
// Reset clears the delay line (valid bits per entry), the phase and the
// pipeline and output valid flags; no clearing pass is needed.
// Depends on hbd_pkg, hbd_ctrl and hbd_datapath.
module halfband_fir_decimator_top
    import hbd_pkg::*;
#(
    parameter int TAP_COUNT = TAP_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // [15:0] in_sample
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [15:0] out_sample
    output logic              m_axis_tuser    // [0] saturated
);

    hbd_cmd_t cmd;
    hbd_sts_t sts;
    sample_t  out_sample;

    hbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hbd_datapath #(
        .TAP_COUNT (TAP_COUNT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .in_sample  (sample_t'(s_axis_tdata)),
        .out_ready  (m_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_sample (out_sample),
        .saturated  (m_axis_tuser)
    );

    assign m_axis_tdata = DATA_W'(out_sample);

`ifndef SYNTHESIS
    // Intake opens only with the multiply pipeline empty
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !sts.pipe_busy)
        else $error("intake open while products are in flight");

    // A transaction that starts a sum closes intake next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> !s_axis_tready)
        else $error("intake still open after a sum started");

    // Never overwrite a result the receiver has not taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("pending result overwritten");
`endif

endmodule
